// ===== sv/ble_module_frame_deframer_core_macros.svh =====
// Assertion helpers for the frame deframer.
// Each expects clk_i and rst_ni in scope.
`ifndef BLE_MODULE_FRAME_DEFRAMER_CORE_MACROS_SVH
`define BLE_MODULE_FRAME_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication.
`define BMFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BMFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bmfd_pkg.sv =====
`timescale 1ns / 1ps

package bmfd_pkg;

  // Default sync word, "itaz".
  localparam logic [31:0] SYNC_RESET = 32'h6974_617A;

  localparam int unsigned ADDR_W = 48;

  // Register index, taken from the word-aligned APB address.
  localparam logic REG_SYNC_WORD = 1'b0;

  localparam logic KIND_PAYLOAD    = 1'b0;
  localparam logic KIND_DESCRIPTOR = 1'b1;

  typedef enum logic [14:0] {
    PH_SYNC0 = 15'h0001,
    PH_SYNC1 = 15'h0002,
    PH_SYNC2 = 15'h0004,
    PH_SYNC3 = 15'h0008,
    PH_CMD_H = 15'h0010,
    PH_CMD_L = 15'h0020,
    PH_RESP  = 15'h0040,
    PH_LEN_H = 15'h0080,
    PH_LEN_L = 15'h0100,
    PH_ADDR  = 15'h0200,
    PH_HND_H = 15'h0400,
    PH_HND_L = 15'h0800,
    PH_WTYPE = 15'h1000,
    PH_DATA  = 15'h2000,
    PH_CSUM  = 15'h4000
  } phase_e;

  // Byte held in the input stage.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } beat_t;

  // One result beat.
  typedef struct packed {
    logic              kind;
    logic [7:0]        data_byte;
    logic [15:0]       data_index;
    logic [15:0]       command;
    logic [7:0]        response;
    logic [15:0]       declared_length;
    logic [15:0]       handle;
    logic [ADDR_W-1:0] peer_address;
    logic              last;
  } res_t;

endpackage

// ===== sv/bmfd_in_reg.sv =====
`timescale 1ns / 1ps

`include "ble_module_frame_deframer_core_macros.svh"

module bmfd_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    rx_byte_i,
  input  logic          take_i,
  output bmfd_pkg::beat_t beat_o
);

  logic       vld_q, vld_d;
  logic [7:0] data_q;

  assign in_ready_o = !vld_q || take_i;

  always_comb begin
    vld_d = vld_q;
    if (in_valid_i && in_ready_o) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= rx_byte_i;
    end
  end

  assign beat_o.vld  = vld_q;
  assign beat_o.data = data_q;

  // the parser must never consume an empty stage
  `BMFD_ASSERT_IMP(a_take_held, take_i, vld_q, "input stage taken while empty")

endmodule

// ===== sv/bmfd_parser.sv =====
`timescale 1ns / 1ps

`include "ble_module_frame_deframer_core_macros.svh"

module bmfd_parser #(
  parameter int unsigned ADDR_BYTES      = 6,
  parameter int unsigned HEADER_OVERHEAD = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bmfd_pkg::beat_t beat_i,
  input  logic            take_i,
  input  logic [31:0]     sync_word_i,
  output logic            load_o,
  output bmfd_pkg::res_t  res_o
);

  bmfd_pkg::phase_e phase_q, phase_d;
  logic [15:0] cmd_q, cmd_d;
  logic [7:0]  resp_q, resp_d;
  logic [15:0] len_q, len_d;
  logic [bmfd_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [15:0] hnd_q, hnd_d;
  logic [15:0] cnt_q, cnt_d;

  logic [7:0]  b;
  logic [7:0]  want;
  logic [16:0] cnt_inc;
  logic [16:0] total;
  logic        fin;
  logic        emit;

  assign b       = beat_i.data;
  assign cnt_inc = {1'b0, cnt_q} + 17'd1;
  assign total   = {1'b0, len_q} - 17'(HEADER_OVERHEAD);
  assign fin     = cnt_inc >= total;

  always_comb begin
    case (phase_q)
      bmfd_pkg::PH_SYNC0: want = sync_word_i[31:24];
      bmfd_pkg::PH_SYNC1: want = sync_word_i[23:16];
      bmfd_pkg::PH_SYNC2: want = sync_word_i[15:8];
      default:            want = sync_word_i[7:0];
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    resp_d  = resp_q;
    len_d   = len_q;
    addr_d  = addr_q;
    hnd_d   = hnd_q;
    cnt_d   = cnt_q;
    emit    = 1'b0;

    res_o.kind            = bmfd_pkg::KIND_PAYLOAD;
    res_o.data_byte       = b;
    res_o.data_index      = cnt_q;
    res_o.command         = cmd_q;
    res_o.response        = resp_q;
    res_o.declared_length = len_q;
    res_o.handle          = hnd_q;
    res_o.peer_address    = addr_q;
    res_o.last            = 1'b0;

    case (phase_q)
      bmfd_pkg::PH_SYNC0: begin
        if (b == want) phase_d = bmfd_pkg::PH_SYNC1;
      end
      bmfd_pkg::PH_SYNC1: begin
        if (b == want) phase_d = bmfd_pkg::PH_SYNC2;
      end
      bmfd_pkg::PH_SYNC2: begin
        if (b == want) phase_d = bmfd_pkg::PH_SYNC3;
      end
      bmfd_pkg::PH_SYNC3: begin
        if (b == want) phase_d = bmfd_pkg::PH_CMD_H;
      end
      bmfd_pkg::PH_CMD_H: begin
        cmd_d   = {b, 8'h00};
        phase_d = bmfd_pkg::PH_CMD_L;
      end
      bmfd_pkg::PH_CMD_L: begin
        cmd_d   = {cmd_q[15:8], b};
        phase_d = bmfd_pkg::PH_RESP;
      end
      bmfd_pkg::PH_RESP: begin
        resp_d  = b;
        phase_d = bmfd_pkg::PH_LEN_H;
      end
      bmfd_pkg::PH_LEN_H: begin
        len_d   = {b, 8'h00};
        phase_d = bmfd_pkg::PH_LEN_L;
      end
      bmfd_pkg::PH_LEN_L: begin
        len_d   = {len_q[15:8], b};
        cnt_d   = '0;
        phase_d = bmfd_pkg::PH_ADDR;
      end
      bmfd_pkg::PH_ADDR: begin
        // only the most recent six bytes survive the shift
        addr_d = {addr_q[bmfd_pkg::ADDR_W-9:0], b};
        if (cnt_inc >= 17'(ADDR_BYTES)) begin
          cnt_d   = '0;
          phase_d = bmfd_pkg::PH_HND_H;
        end else begin
          cnt_d = cnt_inc[15:0];
        end
      end
      bmfd_pkg::PH_HND_H: begin
        hnd_d   = {b, 8'h00};
        phase_d = bmfd_pkg::PH_HND_L;
      end
      bmfd_pkg::PH_HND_L: begin
        hnd_d   = {hnd_q[15:8], b};
        phase_d = bmfd_pkg::PH_WTYPE;
      end
      bmfd_pkg::PH_WTYPE: begin
        // write type is dropped; a short length goes straight to checksum
        cnt_d   = '0;
        phase_d = (len_q > 16'(HEADER_OVERHEAD)) ? bmfd_pkg::PH_DATA : bmfd_pkg::PH_CSUM;
      end
      bmfd_pkg::PH_DATA: begin
        emit       = 1'b1;
        res_o.last = fin;
        cnt_d      = cnt_inc[15:0];
        if (fin) phase_d = bmfd_pkg::PH_CSUM;
      end
      bmfd_pkg::PH_CSUM: begin
        emit       = 1'b1;
        res_o.kind = bmfd_pkg::KIND_DESCRIPTOR;
        phase_d    = bmfd_pkg::PH_SYNC0;
        cmd_d      = '0;
        resp_d     = '0;
        len_d      = '0;
        addr_d     = '0;
        hnd_d      = '0;
        cnt_d      = '0;
      end
      default: begin
        phase_d = bmfd_pkg::PH_SYNC0;
      end
    endcase
  end

  assign load_o = take_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bmfd_pkg::PH_SYNC0;
      cmd_q   <= '0;
      resp_q  <= '0;
      len_q   <= '0;
      addr_q  <= '0;
      hnd_q   <= '0;
      cnt_q   <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      resp_q  <= resp_d;
      len_q   <= len_d;
      addr_q  <= addr_d;
      hnd_q   <= hnd_d;
      cnt_q   <= cnt_d;
    end
  end

  `BMFD_ASSERT_NXT(a_frame_clear, take_i && (phase_q == bmfd_pkg::PH_CSUM),
    (phase_q == bmfd_pkg::PH_SYNC0) && (cnt_q == '0) && (len_q == '0),
    "frame state not cleared after descriptor")
  `BMFD_ASSERT_IMP(a_last_payload, load_o && res_o.last,
    (res_o.kind == bmfd_pkg::KIND_PAYLOAD) && (phase_d == bmfd_pkg::PH_CSUM),
    "last flag outside final payload byte")

endmodule

// ===== sv/bmfd_out_reg.sv =====
`timescale 1ns / 1ps

`include "ble_module_frame_deframer_core_macros.svh"

module bmfd_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  bmfd_pkg::res_t res_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bmfd_pkg::res_t res_o
);

  logic           vld_q, vld_d;
  bmfd_pkg::res_t res_q;

  // free, or being drained this cycle
  assign room_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

  `BMFD_ASSERT_IMP(a_no_overwrite, load_i, !vld_q || out_ready_i,
    "result register overwritten before it was taken")

endmodule

// ===== sv/ble_module_frame_deframer_core.sv =====
`timescale 1ns / 1ps

// Byte-serial deframer for a BLE module link. Each input beat carries one received
// byte. The block hunts for the four sync bytes (sync_word, top byte first; a wrong
// byte simply keeps waiting for the same sync byte), then captures the big-endian
// command, the response byte, the big-endian length, ADDR_BYTES address bytes (the
// last six show on peer_address), the big-endian handle and a write-type byte it
// discards. length - HEADER_OVERHEAD payload bytes follow, each leaving as a result
// beat with its index (last marks the final one); a length at or below the overhead
// means no payload. The checksum byte, unchecked, closes the frame with a descriptor
// beat carrying the payload count, and hunting starts again. Header bytes produce no
// result. Throughput is one byte per clock while the output is not stalled; a byte
// passes an input register and a result register, and its result is offered once the
// phase step between those registers has loaded it. A stalled output backs up through
// both stages. sync_word sits at APB address 0 and should be written only while idle.

module ble_module_frame_deframer_core #(
  parameter int unsigned ADDR_BYTES      = 6,
  parameter int unsigned HEADER_OVERHEAD = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  // received byte stream
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,

  // result beats
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] data_index_o,
  output logic [15:0] command_o,
  output logic [7:0]  response_o,
  output logic [15:0] declared_length_o,
  output logic [15:0] handle_o,
  output logic [47:0] peer_address_o,
  output logic        last_o
);

  logic [31:0]     sync_q;
  bmfd_pkg::beat_t beat;
  bmfd_pkg::res_t  res_new;
  bmfd_pkg::res_t  res_out;
  logic            room;
  logic            take;
  logic            load;

  // ---------------------------------------------------------------------------
  // Configuration: one register, decoded on the word address. Writes land on
  // the access phase; no wait states.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= bmfd_pkg::SYNC_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == bmfd_pkg::REG_SYNC_WORD)) begin
      sync_q <= pwdata;
    end
  end

  assign prdata = (paddr[2] == bmfd_pkg::REG_SYNC_WORD) ? sync_q : '0;

  // ---------------------------------------------------------------------------
  // Datapath: input register -> phase step -> result register.
  // A held byte advances whenever the result register can take a beat, even if
  // that byte produces nothing, so header bytes wait on a stalled output too.
  // ---------------------------------------------------------------------------
  assign take = beat.vld && room;

  bmfd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (take),
    .beat_o     (beat)
  );

  bmfd_parser #(
    .ADDR_BYTES      (ADDR_BYTES),
    .HEADER_OVERHEAD (HEADER_OVERHEAD)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .take_i      (take),
    .sync_word_i (sync_q),
    .load_o      (load),
    .res_o       (res_new)
  );

  bmfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (res_new),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  // result fields onto their own ports
  assign kind_o            = res_out.kind;
  assign data_byte_o       = res_out.data_byte;
  assign data_index_o      = res_out.data_index;
  assign command_o         = res_out.command;
  assign response_o        = res_out.response;
  assign declared_length_o = res_out.declared_length;
  assign handle_o          = res_out.handle;
  assign peer_address_o    = res_out.peer_address;
  assign last_o            = res_out.last;

endmodule

// ===== tb/tb_ble_module_frame_deframer_core.sv =====
`timescale 1ns / 1ps

module tb_ble_module_frame_deframer_core;

  // Build of the block under test: six address bytes, nine bytes of header overhead.
  localparam int unsigned ADDR_BYTES      = 6;
  localparam int unsigned HEADER_OVERHEAD = 9;
  localparam int unsigned SETTLE_CYCLES   = 8;  // result trails its byte through the input and result registers

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  // APB port, idle until a register write
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Byte stream in
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i  = '0;

  // Result beats out
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        kind_o;
  logic [7:0]  data_byte_o;
  logic [15:0] data_index_o;
  logic [15:0] command_o;
  logic [7:0]  response_o;
  logic [15:0] declared_length_o;
  logic [15:0] handle_o;
  logic [47:0] peer_address_o;
  logic        last_o;

  ble_module_frame_deframer_core #(
    .ADDR_BYTES      (ADDR_BYTES),
    .HEADER_OVERHEAD (HEADER_OVERHEAD)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .data_byte_o       (data_byte_o),
    .data_index_o      (data_index_o),
    .command_o         (command_o),
    .response_o        (response_o),
    .declared_length_o (declared_length_o),
    .handle_o          (handle_o),
    .peer_address_o    (peer_address_o),
    .last_o            (last_o)
  );

  // ---------------------------------------------------------------------------
  // Shadow deframer. Mirrors the block's parse state and the sync register;
  // fed with every byte the block accepts, it queues the beats due out.
  // ---------------------------------------------------------------------------
  bmfd_pkg::phase_e ph     = bmfd_pkg::PH_SYNC0;
  logic [31:0]      sync_r = bmfd_pkg::SYNC_RESET;
  logic [15:0]      cmd_r  = '0;
  logic [7:0]       resp_r = '0;
  logic [15:0]      len_r  = '0;
  logic [47:0]      addr_r = '0;
  logic [15:0]      hnd_r  = '0;
  logic [15:0]      cnt_r  = '0;

  bmfd_pkg::res_t expected_beats[$];
  logic [7:0]     rx_stream[$];      // bytes waiting for the driver
  int unsigned    accepted_bytes = 0;
  int unsigned    queued_frame_bytes = 0;
  int unsigned    fail_count = 0;

  // Idling odds, in percent, changed per phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_rx = 1'b0;    // long receiver hold-off

  function automatic bmfd_pkg::res_t frame_beat(input logic k, input logic [7:0] b,
                                                input logic [15:0] idx, input logic fin);
    bmfd_pkg::res_t r;
    r.kind            = k;
    r.data_byte       = b;
    r.data_index      = idx;
    r.command         = cmd_r;
    r.response        = resp_r;
    r.declared_length = len_r;
    r.handle          = hnd_r;
    r.peer_address    = addr_r;
    r.last            = fin;
    return r;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    logic [31:0] total;
    logic [15:0] idx;
    logic        fin;
    case (ph)
      // A wrong byte keeps the hunt on the same sync byte
      bmfd_pkg::PH_SYNC0: if (b == sync_r[31:24]) ph = bmfd_pkg::PH_SYNC1;
      bmfd_pkg::PH_SYNC1: if (b == sync_r[23:16]) ph = bmfd_pkg::PH_SYNC2;
      bmfd_pkg::PH_SYNC2: if (b == sync_r[15:8])  ph = bmfd_pkg::PH_SYNC3;
      bmfd_pkg::PH_SYNC3: if (b == sync_r[7:0])   ph = bmfd_pkg::PH_CMD_H;
      bmfd_pkg::PH_CMD_H: begin
        cmd_r = {b, 8'h00};
        ph    = bmfd_pkg::PH_CMD_L;
      end
      bmfd_pkg::PH_CMD_L: begin
        cmd_r[7:0] = b;
        ph         = bmfd_pkg::PH_RESP;
      end
      bmfd_pkg::PH_RESP: begin
        resp_r = b;
        ph     = bmfd_pkg::PH_LEN_H;
      end
      bmfd_pkg::PH_LEN_H: begin
        len_r = {b, 8'h00};
        ph    = bmfd_pkg::PH_LEN_L;
      end
      bmfd_pkg::PH_LEN_L: begin
        len_r[7:0] = b;
        cnt_r      = '0;
        ph         = bmfd_pkg::PH_ADDR;
      end
      bmfd_pkg::PH_ADDR: begin
        addr_r = {addr_r[39:0], b};
        cnt_r  = cnt_r + 16'd1;
        if (cnt_r >= ADDR_BYTES) begin
          cnt_r = '0;
          ph    = bmfd_pkg::PH_HND_H;
        end
      end
      bmfd_pkg::PH_HND_H: begin
        hnd_r = {b, 8'h00};
        ph    = bmfd_pkg::PH_HND_L;
      end
      bmfd_pkg::PH_HND_L: begin
        hnd_r[7:0] = b;
        ph         = bmfd_pkg::PH_WTYPE;
      end
      // Write type is dropped; a short length goes straight to the checksum
      bmfd_pkg::PH_WTYPE: begin
        cnt_r = '0;
        ph    = (32'(len_r) > HEADER_OVERHEAD) ? bmfd_pkg::PH_DATA : bmfd_pkg::PH_CSUM;
      end
      bmfd_pkg::PH_DATA: begin
        total = 32'(len_r) - HEADER_OVERHEAD;
        idx   = cnt_r;
        cnt_r = cnt_r + 16'd1;
        fin   = (32'(cnt_r) >= total);
        if (fin) ph = bmfd_pkg::PH_CSUM;
        expected_beats.push_back(frame_beat(bmfd_pkg::KIND_PAYLOAD, b, idx, fin));
      end
      bmfd_pkg::PH_CSUM: begin
        expected_beats.push_back(frame_beat(bmfd_pkg::KIND_DESCRIPTOR, b, cnt_r, 1'b0));
        ph     = bmfd_pkg::PH_SYNC0;
        cmd_r  = '0;
        resp_r = '0;
        len_r  = '0;
        addr_r = '0;
        hnd_r  = '0;
        cnt_r  = '0;
      end
      default: ph = bmfd_pkg::PH_SYNC0;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one beat offered at a time, held until taken. The shadow deframer
  // sees each byte at the edge where it is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        deframe_byte(rx_byte_i);
        accepted_bytes = accepted_bytes + 1;
      end
      // free to change the offer only when nothing is held or the held byte is taken
      if (!in_valid_i || in_ready_o) begin
        if (rx_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= rx_stream.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each result beat against the oldest expectation, field by field.
  // ---------------------------------------------------------------------------
  function automatic void field_check(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      fail_count = fail_count + 1;
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  task automatic check_beat();
    bmfd_pkg::res_t want;
    if (expected_beats.size() == 0) begin
      fail_count = fail_count + 1;
      $error("result beat with nothing expected: kind %0d data_byte 0x%0h", kind_o,
             data_byte_o);
    end else begin
      want = expected_beats.pop_front();
      field_check("kind", want.kind, kind_o);
      field_check("data_byte", want.data_byte, data_byte_o);
      field_check("data_index", want.data_index, data_index_o);
      field_check("command", want.command, command_o);
      field_check("response", want.response, response_o);
      field_check("declared_length", want.declared_length, declared_length_o);
      field_check("handle", want.handle, handle_o);
      field_check("peer_address", want.peer_address, peer_address_o);
      field_check("last", want.last, last_o);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_beat();
      out_ready_i <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Back-pressure: once the first phase is well under way the receiver stops
  // for a long stretch while bytes keep coming, so both stages fill and
  // in_ready_o has to drop.
  initial begin
    wait (accepted_bytes >= 300);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // A byte that cannot advance the sync hunt under the current sync word
  function automatic logic [7:0] pick_noise();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == sync_r[31:24] || b == sync_r[23:16] || b == sync_r[15:8] ||
           b == sync_r[7:0]);
    return b;
  endfunction

  task automatic push_frame_byte(input logic [7:0] b);
    rx_stream.push_back(b);
    queued_frame_bytes = queued_frame_bytes + 1;
  endtask

  // Well-formed frame with random header and payload. A broken one has
  // stray bytes inside the sync word, which the hunt must ride over.
  task automatic queue_frame(input logic [15:0] len, input bit broken);
    int unsigned n_pay;
    if ($urandom_range(99) < 30)
      repeat ($urandom_range(3, 1)) rx_stream.push_back(pick_noise());
    for (int k = 3; k >= 0; k--) begin
      push_frame_byte(sync_r[8*k +: 8]);
      if (broken && k != 0 && $urandom_range(1) == 1)
        repeat ($urandom_range(2, 1)) rx_stream.push_back(pick_noise());
    end
    repeat (3) push_frame_byte(8'($urandom_range(255)));   // command, response
    push_frame_byte(len[15:8]);
    push_frame_byte(len[7:0]);
    repeat (ADDR_BYTES + 3) push_frame_byte(8'($urandom_range(255)));
    n_pay = (32'(len) > HEADER_OVERHEAD) ? 32'(len) - HEADER_OVERHEAD : 0;
    repeat (n_pay) push_frame_byte(8'($urandom_range(255)));
    push_frame_byte(8'($urandom_range(255)));              // checksum
  endtask

  // Mostly short frames; a quarter with no payload at all
  function automatic logic [15:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return 16'($urandom_range(HEADER_OVERHEAD));
    if (r < 90) return 16'($urandom_range(HEADER_OVERHEAD + 30, HEADER_OVERHEAD + 1));
    return 16'($urandom_range(300, HEADER_OVERHEAD + 31));
  endfunction

  task automatic queue_random_frames(input int unsigned n_bytes);
    int unsigned goal;
    goal = queued_frame_bytes + n_bytes;
    while (queued_frame_bytes < goal) queue_frame(pick_length(), $urandom_range(99) < 20);
  endtask

  // Everything sent and every result back, then a settling wait for header
  // bytes that leave no trace
  task automatic drain();
    while (rx_stream.size() != 0 || in_valid_i || expected_beats.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic reg_idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);           // access edge: register takes the value here
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == bmfd_pkg::REG_SYNC_WORD) sync_r = value;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(posedge clk_i);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned spins;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Phase 0, reset sync word, no idling.
    // Directed frame: a stray byte after the first sync byte, header bytes of
    // all ones and all zeros, length at the overhead so the checksum follows at once.
    rx_stream.push_back(sync_r[31:24]);
    rx_stream.push_back(8'h00);
    rx_stream.push_back(sync_r[23:16]);
    rx_stream.push_back(sync_r[15:8]);
    rx_stream.push_back(sync_r[7:0]);
    rx_stream.push_back(8'hFF);        // command
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(8'h00);        // response
    rx_stream.push_back(8'h00);        // length = overhead
    rx_stream.push_back(8'(HEADER_OVERHEAD));
    for (int k = 0; k < ADDR_BYTES; k++) rx_stream.push_back((k % 2 == 0) ? 8'hFF : 8'h00);
    rx_stream.push_back(8'hFF);        // handle
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'hFF);        // write type
    rx_stream.push_back(8'h00);        // checksum
    queue_random_frames(340);
    drain();

    // Phase 1, all-zero sync word, sender idle three beats in four
    apb_write(bmfd_pkg::REG_SYNC_WORD, 32'h0000_0000);
    set_idling(75, 0);
    queue_random_frames(330);
    drain();

    // Phase 2, all-ones sync word, receiver stalls at 75 percent odds
    apb_write(bmfd_pkg::REG_SYNC_WORD, 32'hFFFF_FFFF);
    set_idling(0, 75);
    queue_random_frames(330);
    drain();

    // Phase 3, random sync word, light idling on both sides
    apb_write(bmfd_pkg::REG_SYNC_WORD, $urandom);
    set_idling(14, 14);
    queue_random_frames(330);

    while (rx_stream.size() != 0 || in_valid_i) @(posedge clk_i);
    spins = 0;
    while (expected_beats.size() != 0 && spins < 20000) begin
      @(posedge clk_i);
      spins++;
    end
    if (expected_beats.size() != 0) begin
      fail_count = fail_count + 1;
      $error("%0d expected result beats never arrived", expected_beats.size());
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("ble_module_frame_deframer_core regression: pass");
    end else begin
      $display("ble_module_frame_deframer_core regression: fail");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("ble_module_frame_deframer_core regression: fail");
    $finish;
  end

endmodule

// ===== ble_module_frame_deframer_core.f =====
+incdir+sv
sv/bmfd_pkg.sv
sv/bmfd_in_reg.sv
sv/bmfd_parser.sv
sv/bmfd_out_reg.sv
sv/ble_module_frame_deframer_core.sv
tb/tb_ble_module_frame_deframer_core.sv
